@@ hw/rtl/md5_message_digest_assert.svh @@
// Assertion shorthands for the MD5 digest block.
// Both sample on the rising edge of clk and are off while rst is high.
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MD5_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("md5 digest check failed");

// Consequent checked in the cycle after the antecedent.
`define MD5_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("md5 digest check failed");

`endif

@@ hw/rtl/md5_pkg.sv @@
package md5_pkg;

  localparam int WORD_W      = 32;
  localparam int BLOCK_WORDS = 16;
  // block queue depth, power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int APB_ADDR_W  = 4;

  localparam logic [31:0] IV_A_RESET = 32'h67452301;
  localparam logic [31:0] IV_B_RESET = 32'hefcdab89;
  localparam logic [31:0] IV_C_RESET = 32'h98badcfe;
  localparam logic [31:0] IV_D_RESET = 32'h10325476;

  localparam logic [7:0] PAD_BYTE       = 8'h80;
  localparam logic [5:0] LEN_FILL_LIMIT = 6'd56;
  localparam logic [5:0] LAST_FILL_POS  = 6'd63;
  localparam logic [5:0] LAST_ROUND     = 6'd63;
  localparam logic [1:0] LAST_WORD_INDEX = 2'd3;

  typedef enum logic [1:0] {
    REG_IV_A,
    REG_IV_B,
    REG_IV_C,
    REG_IV_D
  } md5_reg_t;

  typedef logic [3:0][WORD_W-1:0] md5_state_words_t;

  // one 512-bit block handed from the front to the core
  typedef struct packed {
    logic [BLOCK_WORDS-1:0][WORD_W-1:0] words;
    md5_state_words_t                   iv;
    logic                               first;
    logic                               last_blk;
  } md5_blk_t;

  typedef enum logic [2:0] {
    FR_FILL,
    FR_PUSH_FULL,
    FR_PAD,
    FR_PUSH_OVF,
    FR_PUSH_LAST
  } md5_front_state_t;

  typedef enum logic [1:0] {
    CR_IDLE,
    CR_ROUND,
    CR_ADD,
    CR_OUT
  } md5_core_state_t;

  function automatic logic [31:0] md5_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // rotate amount, indexed by {round group, round[1:0]}
  function automatic logic [4:0] md5_shift(input logic [3:0] idx);
    logic [4:0] s;
    case (idx)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // message word used by round r
  function automatic logic [3:0] md5_msg_index(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0:    g = r[3:0];
      2'd1:    g = 4'(r[3:0] * 4'd5 + 4'd1);
      2'd2:    g = 4'(r[3:0] * 4'd3 + 4'd5);
      default: g = 4'(r[3:0] * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

@@ hw/rtl/md5_front.sv @@
module md5_front #(
  parameter int BYTE_COUNT_WIDTH = 61
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,
  input  logic                      s_tuser,
  input  logic                      s_tlast,
  input  md5_pkg::md5_state_words_t iv_in,
  output logic                      push_valid,
  input  logic                      push_ready,
  output md5_pkg::md5_blk_t         push_blk
);

  md5_pkg::md5_front_state_t state, state_next;
  logic [5:0]                      fill, fill_next;
  logic [BYTE_COUNT_WIDTH-1:0]     cnt, cnt_next;
  logic                            active, active_next;
  logic                            first_pend, first_pend_next;
  logic                            pend_eom, pend_eom_next;
  md5_pkg::md5_state_words_t       iv_lat, iv_lat_next;
  logic [15:0][31:0]               blk, blk_next;
  logic [63:0]                     len;

  // message length in bits
  assign len = 64'(cnt) << 3;

  always_comb begin
    logic [5:0] pos;
    state_next      = state;
    fill_next       = fill;
    cnt_next        = cnt;
    active_next     = active;
    first_pend_next = first_pend;
    pend_eom_next   = pend_eom;
    iv_lat_next     = iv_lat;
    blk_next        = blk;
    s_tready        = (state == md5_pkg::FR_FILL);
    push_valid      = 1'b0;
    push_blk.words    = blk;
    push_blk.iv       = iv_lat;
    push_blk.first    = first_pend;
    push_blk.last_blk = (state == md5_pkg::FR_PUSH_LAST);
    pos = '0;

    case (state)
      md5_pkg::FR_FILL: begin
        if (s_tvalid) begin
          if (!active) begin
            active_next     = 1'b1;
            iv_lat_next     = iv_in;
            first_pend_next = 1'b1;
          end
          if (s_tuser) begin
            blk_next[fill[5:2]][{fill[1:0], 3'b000} +: 8] = s_tdata;
            cnt_next  = cnt + 1'b1;
            fill_next = fill + 6'd1;
          end
          if (s_tuser && fill == md5_pkg::LAST_FILL_POS) begin
            state_next    = md5_pkg::FR_PUSH_FULL;
            pend_eom_next = s_tlast;
          end else if (s_tlast) begin
            state_next = md5_pkg::FR_PAD;
          end
        end
      end
      md5_pkg::FR_PUSH_FULL: begin
        push_valid = 1'b1;
        if (push_ready) begin
          first_pend_next = 1'b0;
          state_next      = pend_eom ? md5_pkg::FR_PAD : md5_pkg::FR_FILL;
        end
      end
      md5_pkg::FR_PAD: begin
        // marker byte at the fill point, zeros above it
        for (int w = 0; w < 16; w++) begin
          for (int b = 0; b < 4; b++) begin
            pos = 6'(w * 4 + b);
            if (pos == fill) begin
              blk_next[w][b*8 +: 8] = md5_pkg::PAD_BYTE;
            end else if (pos > fill) begin
              blk_next[w][b*8 +: 8] = 8'h00;
            end
          end
        end
        if (fill >= md5_pkg::LEN_FILL_LIMIT) begin
          state_next = md5_pkg::FR_PUSH_OVF;
        end else begin
          blk_next[14] = len[31:0];
          blk_next[15] = len[63:32];
          state_next   = md5_pkg::FR_PUSH_LAST;
        end
      end
      md5_pkg::FR_PUSH_OVF: begin
        push_valid = 1'b1;
        if (push_ready) begin
          first_pend_next = 1'b0;
          blk_next        = '0;
          blk_next[14]    = len[31:0];
          blk_next[15]    = len[63:32];
          state_next      = md5_pkg::FR_PUSH_LAST;
        end
      end
      md5_pkg::FR_PUSH_LAST: begin
        push_valid = 1'b1;
        if (push_ready) begin
          first_pend_next = 1'b0;
          active_next     = 1'b0;
          fill_next       = '0;
          cnt_next        = '0;
          state_next      = md5_pkg::FR_FILL;
        end
      end
      default: begin
        state_next = md5_pkg::FR_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= md5_pkg::FR_FILL;
      fill       <= '0;
      cnt        <= '0;
      active     <= 1'b0;
      first_pend <= 1'b0;
      pend_eom   <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      cnt        <= cnt_next;
      active     <= active_next;
      first_pend <= first_pend_next;
      pend_eom   <= pend_eom_next;
    end
    iv_lat <= iv_lat_next;
    blk    <= blk_next;
  end

endmodule

@@ hw/rtl/md5_queue.sv @@
module md5_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  md5_pkg::md5_blk_t push_blk,
  output logic              head_valid,
  input  logic              pop,
  output md5_pkg::md5_blk_t head
);

  localparam int DEPTH = md5_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  md5_pkg::md5_blk_t  slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W:0]     count;
  logic               do_push, do_pop;

  assign push_ready = (count != (PTR_W+1)'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
    if (do_push) begin
      slots[wr_ptr] <= push_blk;
    end
  end

endmodule

@@ hw/rtl/md5_core.sv @@
module md5_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  md5_pkg::md5_blk_t head,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);

  md5_pkg::md5_core_state_t  state, state_next;
  logic [5:0]                rnd, rnd_next;
  logic [1:0]                oidx, oidx_next;
  logic [31:0]               wa, wb, wc, wd, pre;
  logic [31:0]               wa_next, wb_next, wc_next, wd_next, pre_next;
  md5_pkg::md5_state_words_t chain, chain_next, start;
  logic [31:0]               f, rot_in, b_new;
  logic [5:0]                rnd_inc;

  // one round per cycle; pre carries a + K + M for the round being run
  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (wb & wc) | (~wb & wd);
      2'd1:    f = (wd & wb) | (~wd & wc);
      2'd2:    f = wb ^ wc ^ wd;
      default: f = wc ^ (wb | ~wd);
    endcase
    rot_in  = f + pre;
    b_new   = wb + md5_pkg::md5_rotl(rot_in, md5_pkg::md5_shift({rnd[5:4], rnd[1:0]}));
    rnd_inc = rnd + 6'd1;
    start   = head.first ? head.iv : chain;
  end

  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    oidx_next  = oidx;
    wa_next    = wa;
    wb_next    = wb;
    wc_next    = wc;
    wd_next    = wd;
    pre_next   = pre;
    chain_next = chain;
    pop        = 1'b0;
    m_tvalid   = (state == md5_pkg::CR_OUT);
    m_tdata    = chain[oidx];
    m_tuser    = oidx;
    m_tlast    = (oidx == md5_pkg::LAST_WORD_INDEX);

    case (state)
      md5_pkg::CR_IDLE: begin
        if (head_valid) begin
          chain_next = start;
          wa_next    = start[0];
          wb_next    = start[1];
          wc_next    = start[2];
          wd_next    = start[3];
          pre_next   = start[0] + md5_pkg::md5_k(6'd0) + head.words[0];
          rnd_next   = '0;
          state_next = md5_pkg::CR_ROUND;
        end
      end
      md5_pkg::CR_ROUND: begin
        wa_next  = wd;
        wd_next  = wc;
        wc_next  = wb;
        wb_next  = b_new;
        pre_next = wd + md5_pkg::md5_k(rnd_inc)
                 + head.words[md5_pkg::md5_msg_index(rnd_inc)];
        rnd_next = rnd_inc;
        if (rnd == md5_pkg::LAST_ROUND) begin
          state_next = md5_pkg::CR_ADD;
        end
      end
      md5_pkg::CR_ADD: begin
        chain_next[0] = chain[0] + wa;
        chain_next[1] = chain[1] + wb;
        chain_next[2] = chain[2] + wc;
        chain_next[3] = chain[3] + wd;
        pop        = 1'b1;
        oidx_next  = '0;
        state_next = head.last_blk ? md5_pkg::CR_OUT : md5_pkg::CR_IDLE;
      end
      md5_pkg::CR_OUT: begin
        if (m_tready) begin
          oidx_next = oidx + 2'd1;
          if (oidx == md5_pkg::LAST_WORD_INDEX) begin
            state_next = md5_pkg::CR_IDLE;
          end
        end
      end
      default: begin
        state_next = md5_pkg::CR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= md5_pkg::CR_IDLE;
      rnd   <= '0;
      oidx  <= '0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
      oidx  <= oidx_next;
    end
    wa    <= wa_next;
    wb    <= wb_next;
    wc    <= wc_next;
    wd    <= wd_next;
    pre   <= pre_next;
    chain <= chain_next;
  end

endmodule

@@ hw/rtl/md5_message_digest.sv @@
// MD5 digest engine, one message byte per input item.
// Input stream: s_tdata carries the byte, s_tuser[0] says a byte is present
// (low for an empty item, e.g. an empty message), s_tlast ends the message.
// Output stream: four items per message, words A, B, C, D; m_tuser gives the
// word index and m_tlast marks word D.
// APB port: four 32-bit IV registers at 0x0, 0x4, 0x8, 0xC (A..D), sampled
// by the first item of each message; pready is tied high.
// Throughput: the front takes one byte per cycle while filling and pauses to
// queue each full block; up to two finished blocks wait in the block queue.
// The core works through each 64-byte block in steps: load, 64 rounds at one
// round per cycle, chaining add; on long messages its round loop sets the
// pace. After the final item the front pads, the core compresses each
// remaining block (one or two), then the four digest words go out back to
// back while m_tready is high.
// Reset clears the front, the queue and the core and restores the standard
// IVs; no clearing pass is needed. A stalled m_tready holds the current word
// and the core; the front keeps taking bytes until the queue fills.
module md5_message_digest #(
  parameter int BYTE_COUNT_WIDTH = 61
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: [7:0] msg_byte
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,
  // s_tuser: [0] has_byte
  input  logic                           s_tuser,
  input  logic                           s_tlast,
  // m_tdata: [31:0] digest_word
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,
  // m_tuser: [1:0] word_index
  output logic [1:0]                     m_tuser,
  output logic                           m_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [md5_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  md5_pkg::md5_state_words_t iv_regs;
  md5_pkg::md5_reg_t         reg_sel;
  md5_pkg::md5_blk_t         push_blk, head;
  logic                      push_valid, push_ready, head_valid, pop;
  logic                      cfg_wr;

  // ---- configuration registers ----
  assign pready  = 1'b1;
  assign reg_sel = md5_pkg::md5_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = iv_regs[paddr[3:2]];

  always_ff @(posedge clk) begin
    if (rst) begin
      iv_regs[0] <= md5_pkg::IV_A_RESET;
      iv_regs[1] <= md5_pkg::IV_B_RESET;
      iv_regs[2] <= md5_pkg::IV_C_RESET;
      iv_regs[3] <= md5_pkg::IV_D_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        md5_pkg::REG_IV_A: iv_regs[0] <= pwdata;
        md5_pkg::REG_IV_B: iv_regs[1] <= pwdata;
        md5_pkg::REG_IV_C: iv_regs[2] <= pwdata;
        md5_pkg::REG_IV_D: iv_regs[3] <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // ---- front: byte packing and padding ----
  md5_front #(
    .BYTE_COUNT_WIDTH(BYTE_COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .iv_in      (iv_regs),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_blk   (push_blk)
  );

  // ---- block queue between front and core ----
  md5_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_blk   (push_blk),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  // ---- core: compression rounds and digest output ----
  md5_core u_core (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

@@ hw/rtl/md5_checker.sv @@
`include "md5_message_digest_assert.svh"

module md5_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // last flag only on word D
  `MD5_ASSERT_SAME(a_last_on_word_d, m_tvalid, m_tlast == (m_tuser == md5_pkg::LAST_WORD_INDEX))

  // digest words follow each other with no gap, in order
  `MD5_ASSERT_NEXT(a_word_order, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser == ($past(m_tuser) + 2'd1)))

  // a digest cannot start right after the previous one ends
  `MD5_ASSERT_NEXT(a_gap_after_digest, m_tvalid && m_tready && m_tlast, !m_tvalid)

  // stalled word holds
  `MD5_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind md5_message_digest md5_checker u_checker (.*);
